// ----- rtl/bls_pkg.sv -----
package bls_pkg;

   // port field width of every coordinate
   localparam int PIX_BITS = 6;

   // default coordinate width inside the tile
   localparam int COORD_BITS_DEF = 6;

   // controller state codes
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // one line segment request
   typedef struct packed {
      logic [PIX_BITS-1:0] start_x;
      logic [PIX_BITS-1:0] start_y;
      logic [PIX_BITS-1:0] end_x;
      logic [PIX_BITS-1:0] end_y;
   } req_type;

   // one interior pixel
   typedef struct packed {
      logic [PIX_BITS-1:0] pixel_x;
      logic [PIX_BITS-1:0] pixel_y;
      logic                last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic short_line;
      logic last_pixel;
   } sts_type;

endpackage

// ----- rtl/bls_ctrl.sv -----
module bls_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  bls_pkg::sts_type  sts,
   output bls_pkg::cmd_type  cmd
);

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic slot_free;

   // output register can take a new pixel
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == bls_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load = req_valid && req_ready;
   assign cmd.step = (state_ff == bls_pkg::ST_RUN) && slot_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bls_pkg::ST_IDLE: begin
            if (cmd.load && !sts.short_line) begin
               state_in = bls_pkg::ST_RUN;
            end
         end
         bls_pkg::ST_RUN: begin
            if (cmd.step && sts.last_pixel) begin
               state_in = bls_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bls_pkg::ST_IDLE;
         end
      endcase
   end

   // output valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bls_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/bls_datapath.sv -----
module bls_datapath #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input  logic              clock,
   input  bls_pkg::req_type  req_data,
   output bls_pkg::rsp_type  rsp_data,
   input  bls_pkg::cmd_type  cmd,
   output bls_pkg::sts_type  sts
);

   localparam int CB = COORD_BITS;
   // error term holds values from -4*2^CB to 4*2^CB-1
   localparam int EW = COORD_BITS + 3;

   logic [CB-1:0] ax;
   logic [CB-1:0] ay;
   logic [CB-1:0] bx;
   logic [CB-1:0] by;
   logic [CB-1:0] dx_abs;
   logic [CB-1:0] dy_abs;
   logic          steep;
   logic [CB-1:0] a_maj;
   logic [CB-1:0] a_min;
   logic [CB-1:0] b_maj;
   logic [CB-1:0] b_min;
   logic [CB-1:0] lo_maj;
   logic [CB-1:0] lo_min;
   logic [CB-1:0] hi_min;
   logic [CB-1:0] dmaj;
   logic [CB-1:0] dmin;

   logic [CB-1:0]        maj_ff, maj_in;
   logic [CB-1:0]        mnr_ff, mnr_in;
   logic signed [EW-1:0] e_ff, e_in;
   logic signed [EW-1:0] dmin2_ff;
   logic signed [EW-1:0] dmaj2_ff;
   logic                 down_ff;
   logic                 steep_ff;
   logic [CB-1:0]        cnt_ff;
   logic signed [EW-1:0] e_sum;
   bls_pkg::rsp_type     rsp_ff;
   bls_pkg::rsp_type     rsp_in;

   // masked endpoints
   assign ax = req_data.start_x[CB-1:0];
   assign ay = req_data.start_y[CB-1:0];
   assign bx = req_data.end_x[CB-1:0];
   assign by = req_data.end_y[CB-1:0];

   // axis lengths and steep test
   assign dx_abs = (ax >= bx) ? (ax - bx) : (bx - ax);
   assign dy_abs = (ay >= by) ? (ay - by) : (by - ay);
   assign steep  = dy_abs > dx_abs;

   // walk along the major axis
   assign a_maj = steep ? ay : ax;
   assign a_min = steep ? ax : ay;
   assign b_maj = steep ? by : bx;
   assign b_min = steep ? bx : by;

   // start from the lower end of the major axis
   assign lo_maj = (a_maj > b_maj) ? b_maj : a_maj;
   assign lo_min = (a_maj > b_maj) ? b_min : a_min;
   assign hi_min = (a_maj > b_maj) ? a_min : b_min;

   assign dmaj = steep ? dy_abs : dx_abs;
   assign dmin = steep ? dx_abs : dy_abs;

   // major length of zero or one gives no interior pixel
   assign sts.short_line = (dmaj <= CB'(1));
   assign sts.last_pixel = (cnt_ff == CB'(1));

   // one bresenham step
   assign e_sum = e_ff + dmin2_ff;

   always_comb begin
      maj_in = maj_ff + CB'(1);
      mnr_in = mnr_ff;
      e_in   = e_sum;
      if (!e_sum[EW-1]) begin
         mnr_in = down_ff ? (mnr_ff - CB'(1)) : (mnr_ff + CB'(1));
         e_in   = e_sum - dmaj2_ff;
      end
   end

   // swap back for steep lines
   always_comb begin
      if (steep_ff) begin
         rsp_in.pixel_x = bls_pkg::PIX_BITS'(mnr_in);
         rsp_in.pixel_y = bls_pkg::PIX_BITS'(maj_in);
      end else begin
         rsp_in.pixel_x = bls_pkg::PIX_BITS'(maj_in);
         rsp_in.pixel_y = bls_pkg::PIX_BITS'(mnr_in);
      end
      rsp_in.last = sts.last_pixel;
   end

   // line setup on accept, one pixel per step
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         maj_ff   <= lo_maj;
         mnr_ff   <= lo_min;
         // first step adds 2*dmin, so start at -dmaj
         e_ff     <= -$signed(EW'(dmaj));
         dmin2_ff <= $signed(EW'({dmin, 1'b0}));
         dmaj2_ff <= $signed(EW'({dmaj, 1'b0}));
         down_ff  <= hi_min < lo_min;
         steep_ff <= steep;
         cnt_ff   <= dmaj - CB'(1);
      end else if (cmd.step) begin
         maj_ff <= maj_in;
         mnr_ff <= mnr_in;
         e_ff   <= e_in;
         cnt_ff <= cnt_ff - CB'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/bresenham_line_stepper.sv -----
// channel   direction  handshake              payload
// request   in         req_valid / req_ready  req_data  (bls_pkg::req_type)
// pixel     out        rsp_valid / rsp_ready  rsp_data  (bls_pkg::rsp_type)
//
// a request is set up in the cycle it is accepted, then the stepper makes
// one interior pixel per cycle while rsp_ready does not stall the output;
// a line with no interior pixel makes no pixel at all.
// the next request is taken once the last pixel enters the output register.
// reset clears the controller and the output valid flag only.
// a stalled rsp_ready holds the pixel in the output register and stops stepping.
module bresenham_line_stepper #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bls_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bls_pkg::rsp_type  rsp_data
);

   bls_pkg::cmd_type cmd;
   bls_pkg::sts_type sts;

   // sequencing
   bls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // line setup and stepping
   bls_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule
